// File: hdl/sfs_pkg.sv
// shared types and constants of the sprite frame sequencer
package sfs_pkg;

  localparam int unsigned BOUNCE_W = 7;
  localparam int unsigned FRAME_OUT_W = 6;

  localparam logic [BOUNCE_W-1:0] BOUNCE_OFF = 7'h7f;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_REPEAT   = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  typedef struct packed {
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   running;
    logic                   append_dropped;
  } sfs_res_t;

endpackage

// File: hdl/sfs_ram.sv
// generic simple dual-port ram with registered read
module sfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/sfs_adv.sv
// frame step with end rules of the play modes
module sfs_adv #(
  parameter int unsigned FW = 6,
  parameter int unsigned CW = 7
) (
  input  logic [FW-1:0]                  cur_i,
  input  logic [CW-1:0]                  count_i,
  input  logic                           back_i,
  input  logic [1:0]                     mode_i,
  input  logic [sfs_pkg::BOUNCE_W-1:0]   bounce_i,
  output logic [FW-1:0]                  next_o,
  output logic                           back_o,
  output logic                           stop_o
);

  import sfs_pkg::*;

  localparam int unsigned NW = (FW + 2 > BOUNCE_W + 1) ? FW + 2 : BOUNCE_W + 1;

  logic signed [NW-1:0] nxt;
  logic signed [NW-1:0] last;
  logic signed [NW-1:0] bnc;
  logic signed [NW-1:0] res;

  always_comb begin
    nxt    = back_i ? $signed(NW'(cur_i)) - NW'(1) : $signed(NW'(cur_i)) + NW'(1);
    last   = $signed(NW'(count_i)) - NW'(1);
    bnc    = NW'($signed(bounce_i));
    res    = nxt;
    back_o = back_i;
    stop_o = 1'b0;
    if (mode_i == MODE_PINGPONG) begin
      if (nxt <= 0) begin
        res    = '0;
        back_o = ~back_i;
      end else if (nxt >= last) begin
        res    = last;
        back_o = ~back_i;
      end else if (nxt == bnc) begin
        back_o = ~back_i;
      end
    end else if (nxt < 0) begin
      res = '0;
    end else if (nxt > last || nxt == bnc) begin
      if (mode_i == MODE_REPEAT) begin
        res = '0;
      end else begin
        res    = nxt - NW'(1);
        stop_o = 1'b1;
      end
    end
    next_o = res[FW-1:0];
  end

endmodule

// File: hdl/sfs_ofifo.sv
// two-entry result queue on the output side
module sfs_ofifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfs_pkg::sfs_res_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output sfs_pkg::sfs_res_t data_o
);

  import sfs_pkg::*;

  sfs_res_t   mem_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rp_q];

endmodule

// File: hdl/sprite_frame_sequencer.sv
// top level of the sprite frame sequencer
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o  opcode_i, time_value_i, play_mode_in_i
//  out      output     out_valid_o / out_stall_i frame_index_o, running_o, append_dropped_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (bounce frame)
//
// a tick that steps the frame and a restart pass through the load state,
// which waits on the delay table read of the new frame
// the delay of the current frame is held in a register beside the table
// reset clears control state only, the delay table needs no clearing pass
// results queue in two entries; input stalls in the load cycle and while both are taken
module sprite_frame_sequencer #(
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned TIME_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [15:0]                  time_value_i,
  input  logic [1:0]                   play_mode_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [5:0]                   frame_index_o,
  output logic                         running_o,
  output logic                         append_dropped_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfs_pkg::BOUNCE_W-1:0] cfg_data_i
);

  import sfs_pkg::*;

  localparam int unsigned FW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned AW = TIME_BITS + 2;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } st_e;

  st_e                   st_q, st_d;
  logic                  sub_q, sub_d;
  logic signed [AW-1:0]  el_q, el_d;
  logic [FW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         fc_q, fc_d;
  logic                  back_q, back_d;
  logic                  run_q, run_d;
  logic [1:0]            mode_q, mode_d;
  logic [TIME_BITS-1:0]  dly_q, dly_d;
  logic [BOUNCE_W-1:0]   bnc_q;

  logic                  acc;
  logic                  fifo_full;
  logic                  fifo_pop;
  sfs_res_t              res;
  sfs_res_t              res_out;
  logic [TIME_BITS-1:0]  tv;
  logic                  tick_go;
  logic                  adv;
  logic                  room;
  logic signed [AW:0]    sum;
  logic signed [AW-1:0]  el_add;
  logic signed [AW:0]    diff;
  logic signed [AW-1:0]  el_sub;
  logic                  ram_we;
  logic [FW-1:0]         ram_raddr;
  logic [TIME_BITS-1:0]  ram_rdata;
  logic [FW-1:0]         adv_next;
  logic                  adv_back;
  logic                  adv_stop;

  assign tv          = TIME_BITS'(time_value_i);
  assign in_stall_o  = (st_q != ST_IDLE) || fifo_full;
  assign acc         = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign room        = (fc_q < CW'(MAX_FRAMES));
  assign fifo_pop    = out_valid_o && !out_stall_i;

  // saturating add of elapsed time and saturating subtract of the loaded frame delay
  always_comb begin
    sum = $signed({el_q[AW-1], el_q}) + $signed((AW + 1)'(tv));
    if (sum[AW] != sum[AW-1]) begin
      el_add = sum[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
    end else begin
      el_add = sum[AW-1:0];
    end
    diff = $signed({el_q[AW-1], el_q}) - $signed((AW + 1)'(ram_rdata));
    if (diff[AW] != diff[AW-1]) begin
      el_sub = diff[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
    end else begin
      el_sub = diff[AW-1:0];
    end
  end

  sfs_adv #(
    .FW (FW),
    .CW (CW)
  ) u_adv (
    .cur_i    (cur_q),
    .count_i  (fc_q),
    .back_i   (back_q),
    .mode_i   (mode_q),
    .bounce_i (bnc_q),
    .next_o   (adv_next),
    .back_o   (adv_back),
    .stop_o   (adv_stop)
  );

  always_comb begin
    st_d    = st_q;
    sub_d   = sub_q;
    el_d    = el_q;
    cur_d   = cur_q;
    fc_d    = fc_q;
    back_d  = back_q;
    run_d   = run_q;
    mode_d  = mode_q;
    dly_d   = dly_q;
    tick_go = 1'b0;
    adv     = 1'b0;
    ram_we  = 1'b0;
    ram_raddr = '0;
    res.append_dropped = 1'b0;

    if (st_q == ST_LOAD) begin
      dly_d = ram_rdata;
      st_d  = ST_IDLE;
      if (sub_q) begin
        el_d = el_sub;
      end
    end

    if (acc) begin
      case (op_e'(opcode_i))
        OP_TICK: begin
          tick_go = run_q && (fc_q != '0) && (CW'(cur_q) < fc_q);
          if (tick_go) begin
            el_d = el_add;
            adv  = (el_add > $signed(AW'(dly_q)));
          end
          if (adv) begin
            cur_d     = adv_next;
            back_d    = adv_back;
            run_d     = run_q && !adv_stop;
            ram_raddr = adv_next;
            st_d      = ST_LOAD;
            sub_d     = 1'b1;
          end
        end
        OP_APPEND: begin
          if (room) begin
            ram_we = 1'b1;
            fc_d   = fc_q + CW'(1);
            if (fc_q == CW'(cur_q)) begin
              dly_d = tv;
            end
          end else begin
            res.append_dropped = 1'b1;
          end
        end
        OP_RESTART: begin
          mode_d    = play_mode_in_i;
          cur_d     = '0;
          back_d    = 1'b0;
          run_d     = 1'b1;
          ram_raddr = '0;
          st_d      = ST_LOAD;
          sub_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end

    res.frame_index = FRAME_OUT_W'(cur_d);
    res.running     = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      sub_q  <= 1'b0;
      el_q   <= '0;
      cur_q  <= '0;
      fc_q   <= '0;
      back_q <= 1'b0;
      run_q  <= 1'b0;
      mode_q <= MODE_ONCE;
      bnc_q  <= BOUNCE_OFF;
    end else begin
      st_q   <= st_d;
      sub_q  <= sub_d;
      el_q   <= el_d;
      cur_q  <= cur_d;
      fc_q   <= fc_d;
      back_q <= back_d;
      run_q  <= run_d;
      mode_q <= mode_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bnc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q <= dly_d;
  end

  sfs_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fc_q[FW-1:0]),
    .wdata_i (tv),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfs_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (res),
    .pop_i   (fifo_pop),
    .valid_o (out_valid_o),
    .full_o  (fifo_full),
    .data_o  (res_out)
  );

  assign frame_index_o    = res_out.frame_index;
  assign running_o        = res_out.running;
  assign append_dropped_o = res_out.append_dropped;

endmodule

// File: test/testbench.sv
// self-checking testbench for the sprite frame sequencer
`timescale 1ns / 1ps

module testbench;
  import sfs_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int TABLE_DEPTH = 64;
  localparam int ACC_HI = 131071;
  localparam int ACC_LO = -131072;
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 75;
  localparam int SCRIPT_ROWS = 25;

  typedef struct packed {
    op_e         op;
    logic [15:0] tv;
    logic [1:0]  pm;
  } anim_item_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] tv;
    logic [1:0]  pm;
    logic        fixed;
    sfs_res_t    res;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          opcode = OP_NOP;
  logic [15:0]         time_value = '0;
  logic [1:0]          play_mode_in = MODE_ONCE;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [5:0]          frame_index;
  logic                running;
  logic                append_dropped;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BOUNCE_W-1:0] cfg_data = BOUNCE_OFF;

  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;
  bit hold_wanted = 1'b0;
  int fault_count = 0;

  sfs_res_t frame_status_q[$];

  // predicted state of the sequencer
  logic [15:0] frame_delay [TABLE_DEPTH];
  int          frames_held = 0;
  int          cur_frame = 0;
  int          acc = 0;
  bit          backward = 1'b0;
  bit          playing = 1'b0;
  logic [1:0]  play_mode = MODE_ONCE;
  int          bounce = -1;

  sprite_frame_sequencer u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .time_value_i     (time_value),
    .play_mode_in_i   (play_mode_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .frame_index_o    (frame_index),
    .running_o        (running),
    .append_dropped_o (append_dropped),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_acc(input int v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  function automatic sfs_res_t sequence_step(input anim_item_t it);
    sfs_res_t r;
    int last;
    int nxt;
    r = '0;
    case (it.op)
      OP_TICK: begin
        if (playing && frames_held > 0 && cur_frame < frames_held) begin
          acc = clamp_acc(acc + int'(it.tv));
          if (acc > int'(frame_delay[cur_frame])) begin
            last = frames_held - 1;
            nxt = backward ? cur_frame - 1 : cur_frame + 1;
            if (play_mode == MODE_PINGPONG) begin
              if (nxt <= 0) begin
                nxt = 0;
                backward = !backward;
              end else if (nxt >= last) begin
                nxt = last;
                backward = !backward;
              end else if (nxt == bounce) begin
                backward = !backward;
              end
            end else if (nxt < 0) begin
              nxt = 0;
            end else if (nxt > last || nxt == bounce) begin
              if (play_mode == MODE_REPEAT) begin
                nxt = 0;
              end else begin
                nxt = nxt - 1;
                playing = 1'b0;
              end
            end
            cur_frame = nxt;
            acc = clamp_acc(acc - int'(frame_delay[cur_frame]));
          end
        end
      end
      OP_APPEND: begin
        if (frames_held < TABLE_DEPTH) begin
          frame_delay[frames_held] = it.tv;
          frames_held++;
        end else begin
          r.append_dropped = 1'b1;
        end
      end
      OP_RESTART: begin
        play_mode = it.pm;
        cur_frame = 0;
        backward = 1'b0;
        playing = 1'b1;
      end
      default: ;
    endcase
    r.frame_index = cur_frame[5:0];
    r.running = playing;
    return r;
  endfunction

  function automatic void note_fault(input string what, input int want, input int got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sfs_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_status_q.size() == 0) begin
        note_fault("unexpected item", 0, 1);
      end else begin
        want = frame_status_q.pop_front();
        if (frame_index !== want.frame_index)
          note_fault("frame_index", want.frame_index, frame_index);
        if (running !== want.running)
          note_fault("running", want.running, running);
        if (append_dropped !== want.append_dropped)
          note_fault("append_dropped", want.append_dropped, append_dropped);
      end
    end
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_wanted && held < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        held++;
      end else if (quiet_recv) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  task automatic send_item(input anim_item_t it, input bit fixed, input sfs_res_t fixed_res);
    sfs_res_t predicted;
    while (!quiet_send && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    time_value <= it.tv;
    play_mode_in <= it.pm;
    do @(posedge clk); while (in_stall);
    predicted = sequence_step(it);
    frame_status_q.insert(frame_status_q.size(), fixed ? fixed_res : predicted);
  endtask

  task automatic wait_drained();
    while (frame_status_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_bounce(input logic [BOUNCE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bounce = int'($signed(v));
  endtask

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    script_row_t script [SCRIPT_ROWS];
    logic [BOUNCE_W-1:0] bounce_plan [RANDOM_PHASES];
    anim_item_t it;
    int roll;

    script = '{
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b1, '{6'd0, 1'b0, 1'b0}},
      '{OP_RESTART, 16'h0000, MODE_ONCE,     1'b1, '{6'd0, 1'b1, 1'b0}},
      '{OP_TICK,    16'hffff, MODE_ONCE,     1'b1, '{6'd0, 1'b1, 1'b0}},
      '{OP_APPEND,  16'h0000, MODE_ONCE,     1'b1, '{6'd0, 1'b1, 1'b0}},
      '{OP_RESTART, 16'h0000, MODE_PINGPONG, 1'b1, '{6'd0, 1'b1, 1'b0}},
      '{OP_TICK,    16'h0001, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'hffff, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'hffff, MODE_ONCE,     1'b0, '0},
      '{OP_APPEND,  16'hffff, MODE_ONCE,     1'b0, '0},
      '{OP_APPEND,  16'h0003, MODE_ONCE,     1'b0, '0},
      '{OP_RESTART, 16'h0000, MODE_SPARE,    1'b1, '{6'd0, 1'b1, 1'b0}},
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'hffff, MODE_ONCE,     1'b0, '0},
      '{OP_NOP,     16'hffff, MODE_SPARE,    1'b0, '0},
      '{OP_RESTART, 16'h0000, MODE_REPEAT,   1'b1, '{6'd0, 1'b1, 1'b0}},
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'hffff, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'h000a, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b0, '0},
      '{OP_RESTART, 16'h0000, MODE_PINGPONG, 1'b1, '{6'd0, 1'b1, 1'b0}},
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'hffff, MODE_ONCE,     1'b0, '0},
      '{OP_TICK,    16'h0000, MODE_ONCE,     1'b0, '0}
    };
    bounce_plan = '{BOUNCE_OFF, 7'd63, 7'd0, 7'h40,
                    7'($urandom_range(8, 1)), 7'($urandom_range(127))};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      it.op = script[i].op;
      it.tv = script[i].tv;
      it.pm = script[i].pm;
      send_item(it, script[i].fixed, script[i].res);
    end
    in_valid <= 1'b0;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // sender holds back until every item is back before the register write
      wait_drained();
      write_bounce(bounce_plan[phase]);
      quiet_send = (phase == 2 || phase == 3);
      quiet_recv = (phase == 2);
      hold_wanted = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        it.pm = 2'($urandom_range(3));
        if (roll < 4) begin
          it.op = OP_RESTART;
          it.tv = 16'($urandom);
        end else if (roll < 7) begin
          it.op = OP_NOP;
          it.tv = 16'($urandom);
        end else if (roll < ((frames_held < TABLE_DEPTH) ? 27 : 12)) begin
          it.op = OP_APPEND;
          roll = $urandom_range(99);
          if (roll < 5) it.tv = 16'hffff;
          else if (roll < 15) it.tv = 16'($urandom);
          else if (roll < 25) it.tv = 16'h0000;
          else it.tv = 16'($urandom_range(30));
        end else begin
          it.op = OP_TICK;
          roll = $urandom_range(99);
          if (roll < 8) it.tv = 16'hffff;
          else if (roll < 20) it.tv = 16'($urandom);
          else it.tv = 16'($urandom_range(40));
        end
        send_item(it, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    quiet_recv = 1'b0;
    while (frame_status_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sfs_pkg.sv
hdl/sfs_ram.sv
hdl/sfs_adv.sv
hdl/sfs_ofifo.sv
hdl/sprite_frame_sequencer.sv
test/testbench.sv
